/* design/qmac_pkg.sv */
// qmac_pkg: shared codes for the quaternion multiply-accumulate block
// no dependencies; imported by qmac_fin and the top level
`default_nettype none

package qmac_pkg;

    typedef logic t_kind;

    // item kind codes
    localparam t_kind KIND_MUL = 1'b0;
    localparam t_kind KIND_MAC = 1'b1;

endpackage

`default_nettype wire

/* design/qmac_in_if.sv */
// qmac_in_if: operand channel carrying one item of two quaternions and a kind bit
// valid / ready handshake; no package dependency
`default_nettype none

interface qmac_in_if #(
    parameter int DW = 16
);
    logic                 valid;
    logic                 ready;
    logic                 kind;
    logic signed [DW-1:0] a_real;
    logic signed [DW-1:0] a_i;
    logic signed [DW-1:0] a_j;
    logic signed [DW-1:0] a_k;
    logic signed [DW-1:0] b_real;
    logic signed [DW-1:0] b_i;
    logic signed [DW-1:0] b_j;
    logic signed [DW-1:0] b_k;

    modport source (
        output valid, kind, a_real, a_i, a_j, a_k, b_real, b_i, b_j, b_k,
        input  ready
    );

    modport sink (
        input  valid, kind, a_real, a_i, a_j, a_k, b_real, b_i, b_j, b_k,
        output ready
    );
endinterface

`default_nettype wire

/* design/qmac_out_if.sv */
// qmac_out_if: result channel carrying the accumulator and the saturation flag
// valid / ready handshake; no package dependency
`default_nettype none

interface qmac_out_if #(
    parameter int DW = 16
);
    logic                 valid;
    logic                 ready;
    logic signed [DW-1:0] out_real;
    logic signed [DW-1:0] out_i;
    logic signed [DW-1:0] out_j;
    logic signed [DW-1:0] out_k;
    logic                 saturated;

    modport source (
        output valid, out_real, out_i, out_j, out_k, saturated,
        input  ready
    );

    modport sink (
        input  valid, out_real, out_i, out_j, out_k, saturated,
        output ready
    );
endinterface

`default_nettype wire

/* design/qmac_prod.sv */
// qmac_prod: pre-adders and the eight parallel multipliers of the product
// purely combinational; no package dependency
`default_nettype none

module qmac_prod #(
    parameter int DATA_WIDTH = 16
) (
    input  wire logic signed [DATA_WIDTH-1:0]   i_aw,
    input  wire logic signed [DATA_WIDTH-1:0]   i_ax,
    input  wire logic signed [DATA_WIDTH-1:0]   i_ay,
    input  wire logic signed [DATA_WIDTH-1:0]   i_az,
    input  wire logic signed [DATA_WIDTH-1:0]   i_bw,
    input  wire logic signed [DATA_WIDTH-1:0]   i_bx,
    input  wire logic signed [DATA_WIDTH-1:0]   i_by,
    input  wire logic signed [DATA_WIDTH-1:0]   i_bz,
    output logic signed [2*DATA_WIDTH+1:0]      o_pa,
    output logic signed [2*DATA_WIDTH+1:0]      o_pb,
    output logic signed [2*DATA_WIDTH+1:0]      o_pc,
    output logic signed [2*DATA_WIDTH+1:0]      o_pd,
    output logic signed [2*DATA_WIDTH+1:0]      o_pe,
    output logic signed [2*DATA_WIDTH+1:0]      o_pf,
    output logic signed [2*DATA_WIDTH+1:0]      o_pg,
    output logic signed [2*DATA_WIDTH+1:0]      o_ph
);

    localparam int SW = DATA_WIDTH + 1;

    logic signed [SW-1:0] a_wpx, a_zmy, a_xmw, a_ypz, a_xpz, a_xmz, a_wpy, a_wmy;
    logic signed [SW-1:0] b_wpx, b_ymz, b_ypz, b_xmw, b_xpy, b_xmy, b_wmz, b_wpz;

    always_comb begin
        a_wpx = SW'(i_aw) + SW'(i_ax);
        a_zmy = SW'(i_az) - SW'(i_ay);
        a_xmw = SW'(i_ax) - SW'(i_aw);
        a_ypz = SW'(i_ay) + SW'(i_az);
        a_xpz = SW'(i_ax) + SW'(i_az);
        a_xmz = SW'(i_ax) - SW'(i_az);
        a_wpy = SW'(i_aw) + SW'(i_ay);
        a_wmy = SW'(i_aw) - SW'(i_ay);

        b_wpx = SW'(i_bw) + SW'(i_bx);
        b_ymz = SW'(i_by) - SW'(i_bz);
        b_ypz = SW'(i_by) + SW'(i_bz);
        b_xmw = SW'(i_bx) - SW'(i_bw);
        b_xpy = SW'(i_bx) + SW'(i_by);
        b_xmy = SW'(i_bx) - SW'(i_by);
        b_wmz = SW'(i_bw) - SW'(i_bz);
        b_wpz = SW'(i_bw) + SW'(i_bz);

        o_pa = a_wpx * b_wpx;
        o_pb = a_zmy * b_ymz;
        o_pc = a_xmw * b_ypz;
        o_pd = a_ypz * b_xmw;
        o_pe = a_xpz * b_xpy;
        o_pf = a_xmz * b_xmy;
        o_pg = a_wpy * b_wmz;
        o_ph = a_wmy * b_wpz;
    end

endmodule

`default_nettype wire

/* design/qmac_fin.sv */
// qmac_fin: combines the eight products, rescales, saturates and accumulates
// combinational; uses qmac_pkg for the kind codes
`default_nettype none

module qmac_fin #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 12
) (
    input  wire logic                           i_kind,
    input  wire logic signed [2*DATA_WIDTH+1:0] i_pa,
    input  wire logic signed [2*DATA_WIDTH+1:0] i_pb,
    input  wire logic signed [2*DATA_WIDTH+1:0] i_pc,
    input  wire logic signed [2*DATA_WIDTH+1:0] i_pd,
    input  wire logic signed [2*DATA_WIDTH+1:0] i_pe,
    input  wire logic signed [2*DATA_WIDTH+1:0] i_pf,
    input  wire logic signed [2*DATA_WIDTH+1:0] i_pg,
    input  wire logic signed [2*DATA_WIDTH+1:0] i_ph,
    input  wire logic signed [DATA_WIDTH-1:0]   i_acc_w,
    input  wire logic signed [DATA_WIDTH-1:0]   i_acc_x,
    input  wire logic signed [DATA_WIDTH-1:0]   i_acc_y,
    input  wire logic signed [DATA_WIDTH-1:0]   i_acc_z,
    output logic signed [DATA_WIDTH-1:0]        o_acc_w,
    output logic signed [DATA_WIDTH-1:0]        o_acc_x,
    output logic signed [DATA_WIDTH-1:0]        o_acc_y,
    output logic signed [DATA_WIDTH-1:0]        o_acc_z,
    output logic                                o_sat
);

    import qmac_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int TW = 2 * DATA_WIDTH + 4;
    localparam int SH = FRAC_BITS + 1;
    localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

    // rescale a doubled component and clamp; returns {flag, value}
    function automatic logic [DW:0] rescale(input logic signed [TW-1:0] v);
        logic signed [TW-1:0] s;
        logic                 fits;
        s    = v >>> SH;
        fits = (&s[TW-1:DW-1]) || !(|s[TW-1:DW-1]);
        if (fits) begin
            rescale = {1'b0, s[DW-1:0]};
        end else if (s[TW-1]) begin
            rescale = {1'b1, MINV};
        end else begin
            rescale = {1'b1, MAXV};
        end
    endfunction

    // saturating add of two components; returns {flag, value}
    function automatic logic [DW:0] add_sat(input logic signed [DW-1:0] a,
                                            input logic signed [DW-1:0] b);
        logic signed [DW:0] s;
        s = (DW+1)'(a) + (DW+1)'(b);
        if (s[DW] == s[DW-1]) begin
            add_sat = {1'b0, s[DW-1:0]};
        end else if (s[DW]) begin
            add_sat = {1'b1, MINV};
        end else begin
            add_sat = {1'b1, MAXV};
        end
    endfunction

    logic signed [TW-1:0] ea, eb, ec, ed, ee, ef, eg, eh;
    logic signed [TW-1:0] tw, tx, ty, tz;
    logic [DW:0]          rw, rx, ry, rz;
    logic [DW:0]          sw, sx, sy, sz;

    always_comb begin
        ea = TW'(i_pa);
        eb = TW'(i_pb);
        ec = TW'(i_pc);
        ed = TW'(i_pd);
        ee = TW'(i_pe);
        ef = TW'(i_pf);
        eg = TW'(i_pg);
        eh = TW'(i_ph);

        // twice each exact component
        tw = eb + eb - ee - ef + eg + eh;
        tx = ea + ea - ee - ef - eg - eh;
        ty = ee - ef + eg - eh - ec - ec;
        tz = ee - ef - eg + eh - ed - ed;

        rw = rescale(tw);
        rx = rescale(tx);
        ry = rescale(ty);
        rz = rescale(tz);

        sw = add_sat(i_acc_w, rw[DW-1:0]);
        sx = add_sat(i_acc_x, rx[DW-1:0]);
        sy = add_sat(i_acc_y, ry[DW-1:0]);
        sz = add_sat(i_acc_z, rz[DW-1:0]);

        if (i_kind == KIND_MAC) begin
            o_acc_w = sw[DW-1:0];
            o_acc_x = sx[DW-1:0];
            o_acc_y = sy[DW-1:0];
            o_acc_z = sz[DW-1:0];
            o_sat   = rw[DW] | rx[DW] | ry[DW] | rz[DW]
                    | sw[DW] | sx[DW] | sy[DW] | sz[DW];
        end else begin
            o_acc_w = rw[DW-1:0];
            o_acc_x = rx[DW-1:0];
            o_acc_y = ry[DW-1:0];
            o_acc_z = rz[DW-1:0];
            o_sat   = rw[DW] | rx[DW] | ry[DW] | rz[DW];
        end
    end

endmodule

`default_nettype wire

/* design/quaternion_multiply_accumulate.sv */
// quaternion_multiply_accumulate: top level, three-stage pipeline and accumulator
// depends on qmac_pkg, qmac_in_if, qmac_out_if, qmac_prod and qmac_fin
//
// Quaternion multiply / multiply-accumulate in signed fixed point (Q3.12 at the
// defaults). Each item carries two quaternions and a kind bit; the Hamilton product
// is formed with eight parallel multipliers, shifted back to the input format with
// round toward minus infinity, and saturated. Kind multiply loads the product into
// the accumulator, kind multiply-accumulate adds it with saturation; every item
// returns the new accumulator and a flag set if any clamp occurred. Throughput is
// one item per clock while the result side is ready. An item is registered in the
// operand register on acceptance, its eight products are then registered in the
// product register, and the accumulator update lands in the result register.
// Only the final stage holds the accumulator feedback, which is what lets
// multiply-accumulate items follow each other every cycle. The pipeline keeps
// accepting items while a result waits, until all three stages are full.
`default_nettype none

module quaternion_multiply_accumulate #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 12
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    qmac_in_if.sink     i_in,
    qmac_out_if.source  o_out
);

    import qmac_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int PW = 2 * DATA_WIDTH + 2;

    // stage 0: operand register
    logic                 r_v0;
    t_kind                r_kind0;
    logic signed [DW-1:0] r_aw, r_ax, r_ay, r_az, r_bw, r_bx, r_by, r_bz;

    // stage 1: product register
    logic                 r_v1;
    t_kind                r_kind1;
    logic signed [PW-1:0] r_pa, r_pb, r_pc, r_pd, r_pe, r_pf, r_pg, r_ph;

    // stage 2: accumulator / result register
    logic                 r_v2;
    logic signed [DW-1:0] r_acc_w, r_acc_x, r_acc_y, r_acc_z;
    logic                 r_sat;

    logic                 rdy0, rdy1, rdy2;
    logic signed [PW-1:0] n_pa, n_pb, n_pc, n_pd, n_pe, n_pf, n_pg, n_ph;
    logic signed [DW-1:0] n_acc_w, n_acc_x, n_acc_y, n_acc_z;
    logic                 n_sat;

    // a stage takes a new item when empty or when its item moves on
    assign rdy2 = !r_v2 || o_out.ready;
    assign rdy1 = !r_v1 || rdy2;
    assign rdy0 = !r_v0 || rdy1;

    assign i_in.ready = rdy0;

    qmac_prod #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_prod (
        .i_aw (r_aw),
        .i_ax (r_ax),
        .i_ay (r_ay),
        .i_az (r_az),
        .i_bw (r_bw),
        .i_bx (r_bx),
        .i_by (r_by),
        .i_bz (r_bz),
        .o_pa (n_pa),
        .o_pb (n_pb),
        .o_pc (n_pc),
        .o_pd (n_pd),
        .o_pe (n_pe),
        .o_pf (n_pf),
        .o_pg (n_pg),
        .o_ph (n_ph)
    );

    qmac_fin #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_fin (
        .i_kind  (r_kind1),
        .i_pa    (r_pa),
        .i_pb    (r_pb),
        .i_pc    (r_pc),
        .i_pd    (r_pd),
        .i_pe    (r_pe),
        .i_pf    (r_pf),
        .i_pg    (r_pg),
        .i_ph    (r_ph),
        .i_acc_w (r_acc_w),
        .i_acc_x (r_acc_x),
        .i_acc_y (r_acc_y),
        .i_acc_z (r_acc_z),
        .o_acc_w (n_acc_w),
        .o_acc_x (n_acc_x),
        .o_acc_y (n_acc_y),
        .o_acc_z (n_acc_z),
        .o_sat   (n_sat)
    );

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (rdy0) begin
                r_v0 <= i_in.valid;
            end
            if (rdy1) begin
                r_v1 <= r_v0;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
        end
    end

    // operand and product payload
    always_ff @(posedge i_clk) begin
        if (i_in.valid && rdy0) begin
            r_kind0 <= i_in.kind;
            r_aw    <= i_in.a_real;
            r_ax    <= i_in.a_i;
            r_ay    <= i_in.a_j;
            r_az    <= i_in.a_k;
            r_bw    <= i_in.b_real;
            r_bx    <= i_in.b_i;
            r_by    <= i_in.b_j;
            r_bz    <= i_in.b_k;
        end
        if (r_v0 && rdy1) begin
            r_kind1 <= r_kind0;
            r_pa    <= n_pa;
            r_pb    <= n_pb;
            r_pc    <= n_pc;
            r_pd    <= n_pd;
            r_pe    <= n_pe;
            r_pf    <= n_pf;
            r_pg    <= n_pg;
            r_ph    <= n_ph;
        end
    end

    // accumulator doubles as the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_w <= '0;
            r_acc_x <= '0;
            r_acc_y <= '0;
            r_acc_z <= '0;
            r_sat   <= 1'b0;
        end else if (r_v1 && rdy2) begin
            r_acc_w <= n_acc_w;
            r_acc_x <= n_acc_x;
            r_acc_y <= n_acc_y;
            r_acc_z <= n_acc_z;
            r_sat   <= n_sat;
        end
    end

    assign o_out.valid     = r_v2;
    assign o_out.out_real  = r_acc_w;
    assign o_out.out_i     = r_acc_x;
    assign o_out.out_j     = r_acc_y;
    assign o_out.out_k     = r_acc_z;
    assign o_out.saturated = r_sat;

    // an accepted item always lands in the operand register
    a_accept_to_s0 : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_v0)
        else $error("accepted item missing from operand register");

    // a product stage item moving on always reaches the result register
    a_s1_to_s2 : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && rdy2 |=> r_v2)
        else $error("item lost between product and result stage");

    // with no result pending the pipeline must be able to take an item
    a_ready_when_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v2 |-> i_in.ready)
        else $error("input stalled while result register empty");

endmodule

`default_nettype wire
